>>> hdl/cfws_pkg.sv
// Package for the circular FIFO with search.
// Holds the default sizes, the opcode and status codes, and the handshake field widths.
// Used by circular_fifo_with_search and cfws_ram.
package cfws_pkg;

  // Default sizes
  localparam int DEPTH_DEF      = 64;
  localparam int DATA_WIDTH_DEF = 32;

  // Field widths of the opcode and status codes
  localparam int OP_W = 3;
  localparam int ST_W = 2;

  // Opcodes
  localparam logic [OP_W-1:0] OP_PUSH   = 3'd0;
  localparam logic [OP_W-1:0] OP_POP    = 3'd1;
  localparam logic [OP_W-1:0] OP_PEEK   = 3'd2;
  localparam logic [OP_W-1:0] OP_SEARCH = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;

  // Result status codes
  localparam logic [ST_W-1:0] STAT_OK       = 2'd0;
  localparam logic [ST_W-1:0] STAT_FULL     = 2'd1;
  localparam logic [ST_W-1:0] STAT_EMPTY    = 2'd2;
  localparam logic [ST_W-1:0] STAT_NOTFOUND = 2'd3;

endpackage

>>> hdl/cfws_ram.sv
// Simple dual-port storage for the FIFO: one write port, one read port.
// The read data is registered, so it arrives in the cycle after the address.
// Sizes are handed down from circular_fifo_with_search.
module cfws_ram #(
  parameter int DEPTH      = cfws_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = cfws_pkg::DATA_WIDTH_DEF,
  localparam int ADDR_W    = $clog2(DEPTH)
) (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic [ADDR_W-1:0]     waddr_i,
  input  logic [DATA_WIDTH-1:0] wdata_i,
  input  logic                  re_i,
  input  logic [ADDR_W-1:0]     raddr_i,
  output logic [DATA_WIDTH-1:0] rdata_o
);

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

>>> hdl/circular_fifo_with_search.sv
// Circular FIFO with search (cfws_ram storage, cfws_pkg codes). Push, clear, unknown opcodes
// and refused items have the result registered at the accepting edge; pop and peek wait in
// S_READ for the memory, which answers in the cycle after the address; search reads and compares
// the entries oldest first up to a match or the newest one. One item is in flight at a time, so
// push and clear go 1 per cycle, less result stalls; pop, peek and search hold off the next item.
// Reset clears both pointers and the count, sets capacity to DEPTH; memory is not cleared.
module circular_fifo_with_search #(
  parameter int DEPTH      = cfws_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = cfws_pkg::DATA_WIDTH_DEF,
  localparam int SLOT_W    = $clog2(DEPTH),
  localparam int CNT_W     = $clog2(DEPTH + 1),
  localparam int IN_TW     = ((DATA_WIDTH + 7) / 8) * 8,
  localparam int OUT_TW    = ((DATA_WIDTH + SLOT_W + CNT_W + 7) / 8) * 8
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // Capacity register
  input  logic                      cfg_we_i,
  input  logic [CNT_W-1:0]          cfg_wdata_i,
  // Input items
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [IN_TW-1:0]          s_axis_tdata,   // data_in
  input  logic [cfws_pkg::OP_W-1:0] s_axis_tuser,   // opcode
  // Result items
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [OUT_TW-1:0]         m_axis_tdata,   // data_out, slot_index, fill_count
  output logic [cfws_pkg::ST_W-1:0] m_axis_tuser    // status
);

  // Sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;

  logic [1:0]                   state_q, state_d;
  logic [SLOT_W-1:0]            wr_slot_q, wr_slot_d;
  logic [SLOT_W-1:0]            rd_slot_q, rd_slot_d;
  logic [CNT_W-1:0]             count_q, count_d;
  logic [CNT_W-1:0]             cap_q, cap_d;
  logic [DATA_WIDTH-1:0]        key_q, key_d;
  logic [SLOT_W-1:0]            scan_addr_q, scan_addr_d;
  logic [CNT_W-1:0]             scan_n_q, scan_n_d;
  logic                         out_valid_q, out_valid_d;
  logic [cfws_pkg::ST_W-1:0]    out_status_q, out_status_d;
  logic [DATA_WIDTH-1:0]        out_data_q, out_data_d;
  logic [SLOT_W-1:0]            out_slot_q, out_slot_d;
  logic [CNT_W-1:0]             out_count_q, out_count_d;

  logic                         in_acc;
  logic                         out_free;
  logic [cfws_pkg::OP_W-1:0]    op;
  logic signed [DATA_WIDTH-1:0] data_in;
  logic [CNT_W-1:0]             eff_cap;
  logic                         full;
  logic                         empty;
  logic                         mem_we;
  logic                         mem_re;
  logic [SLOT_W-1:0]            mem_raddr;
  logic [DATA_WIDTH-1:0]        mem_rdata;

  // Next slot going downward, wrapping from slot 0 to the top slot in use
  function automatic logic [SLOT_W-1:0] step_down(input logic [SLOT_W-1:0] slot,
                                                  input logic [CNT_W-1:0]  cap);
    logic [CNT_W-1:0] top;
    top = cap - CNT_W'(1);
    return (slot == '0) ? top[SLOT_W-1:0] : slot - SLOT_W'(1);
  endfunction

  assign op      = s_axis_tuser;
  assign data_in = s_axis_tdata[DATA_WIDTH-1:0];

  // Capacity clamped to 1..DEPTH
  always_comb begin
    if (cap_q == '0) begin
      eff_cap = CNT_W'(1);
    end else if (cap_q > CNT_W'(DEPTH)) begin
      eff_cap = CNT_W'(DEPTH);
    end else begin
      eff_cap = cap_q;
    end
  end

  assign full  = (count_q >= eff_cap);
  assign empty = (count_q == '0);

  // Handshake: one item at a time, the output register must be free or draining
  assign out_free      = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE) && out_free;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  assign mem_we = in_acc && (op == cfws_pkg::OP_PUSH) && !full;

  cfws_ram #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (wr_slot_q),
    .wdata_i (data_in),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Sequencer and pointer update
  always_comb begin
    state_d      = state_q;
    wr_slot_d    = wr_slot_q;
    rd_slot_d    = rd_slot_q;
    count_d      = count_q;
    cap_d        = cfg_we_i ? cfg_wdata_i : cap_q;
    key_d        = key_q;
    scan_addr_d  = scan_addr_q;
    scan_n_d     = scan_n_q;
    out_valid_d  = out_valid_q && !m_axis_tready;
    out_status_d = out_status_q;
    out_data_d   = out_data_q;
    out_slot_d   = out_slot_q;
    out_count_d  = out_count_q;
    mem_re       = 1'b0;
    mem_raddr    = rd_slot_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          // Default result: ok, no data, current count
          out_valid_d  = 1'b1;
          out_status_d = cfws_pkg::STAT_OK;
          out_data_d   = '0;
          out_slot_d   = '0;
          out_count_d  = count_q;
          case (op) inside
            cfws_pkg::OP_PUSH: begin
              if (full) begin
                out_status_d = cfws_pkg::STAT_FULL;
              end else begin
                count_d     = count_q + CNT_W'(1);
                out_count_d = count_q + CNT_W'(1);
                wr_slot_d   = step_down(wr_slot_q, eff_cap);
              end
            end
            cfws_pkg::OP_POP, cfws_pkg::OP_PEEK: begin
              if (empty) begin
                out_status_d = cfws_pkg::STAT_EMPTY;
              end else begin
                // Result waits for the memory read
                out_valid_d = 1'b0;
                mem_re      = 1'b1;
                state_d     = S_READ;
                if (op == cfws_pkg::OP_POP) begin
                  count_d   = count_q - CNT_W'(1);
                  rd_slot_d = step_down(rd_slot_q, eff_cap);
                end
              end
            end
            cfws_pkg::OP_SEARCH: begin
              if (empty) begin
                out_status_d = cfws_pkg::STAT_NOTFOUND;
              end else begin
                out_valid_d = 1'b0;
                mem_re      = 1'b1;
                key_d       = data_in;
                scan_addr_d = rd_slot_q;
                scan_n_d    = '0;
                state_d     = S_SCAN;
              end
            end
            cfws_pkg::OP_CLEAR: begin
              wr_slot_d   = '0;
              rd_slot_d   = '0;
              count_d     = '0;
              out_count_d = '0;
            end
            default: begin
            end
          endcase
        end
      end

      S_READ: begin
        out_valid_d  = 1'b1;
        out_status_d = cfws_pkg::STAT_OK;
        out_data_d   = mem_rdata;
        out_slot_d   = '0;
        out_count_d  = count_q;
        state_d      = S_IDLE;
      end

      S_SCAN: begin
        // Compare the entry read last cycle, oldest first
        if (mem_rdata == key_q) begin
          out_valid_d  = 1'b1;
          out_status_d = cfws_pkg::STAT_OK;
          out_data_d   = '0;
          out_slot_d   = scan_addr_q;
          out_count_d  = count_q;
          state_d      = S_IDLE;
        end else if (scan_n_q + CNT_W'(1) == count_q) begin
          out_valid_d  = 1'b1;
          out_status_d = cfws_pkg::STAT_NOTFOUND;
          out_data_d   = '0;
          out_slot_d   = '0;
          out_count_d  = count_q;
          state_d      = S_IDLE;
        end else begin
          mem_re      = 1'b1;
          mem_raddr   = step_down(scan_addr_q, eff_cap);
          scan_addr_d = step_down(scan_addr_q, eff_cap);
          scan_n_d    = scan_n_q + CNT_W'(1);
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      wr_slot_q   <= '0;
      rd_slot_q   <= '0;
      count_q     <= '0;
      cap_q       <= CNT_W'(DEPTH);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wr_slot_q   <= wr_slot_d;
      rd_slot_q   <= rd_slot_d;
      count_q     <= count_d;
      cap_q       <= cap_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    key_q        <= key_d;
    scan_addr_q  <= scan_addr_d;
    scan_n_q     <= scan_n_d;
    out_status_q <= out_status_d;
    out_data_q   <= out_data_d;
    out_slot_q   <= out_slot_d;
    out_count_q  <= out_count_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = OUT_TW'({out_count_q, out_slot_q, out_data_q});

`ifndef NO_ASSERTIONS
  // Count never exceeds the storage depth
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("entry count above DEPTH");

  // No new item while a pop, peek or search is in flight
  a_busy_no_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !s_axis_tready)
    else $error("item accepted while busy");

  // A refused push leaves the write pointer and count alone
  a_full_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (op == cfws_pkg::OP_PUSH) && full) |=> ($stable(wr_slot_q) && $stable(count_q)))
    else $error("refused push changed state");

  // The S_READ state of a pop or peek always yields a valid result next cycle
  a_read_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ) |=> out_valid_q)
    else $error("pop or peek result lost");
`endif

endmodule

>>> verif/circular_fifo_with_search_tb.sv
// Self-checking testbench for circular_fifo_with_search: a directed table, then random phases
// with capacity changes, each result checked against the table or a local FIFO-with-search predictor.
// Depends on cfws_pkg and the circular_fifo_with_search RTL.
module circular_fifo_with_search_tb;

  localparam int DEPTH      = cfws_pkg::DEPTH_DEF;
  localparam int DATA_W     = cfws_pkg::DATA_WIDTH_DEF;
  localparam int OP_W       = cfws_pkg::OP_W;
  localparam int ST_W       = cfws_pkg::ST_W;
  localparam int SLOT_W     = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int IN_TW      = ((DATA_W + 7) / 8) * 8;
  localparam int OUT_TW     = ((DATA_W + SLOT_W + CNT_W + 7) / 8) * 8;
  localparam int SLOT_LSB   = DATA_W;
  localparam int CNT_LSB    = DATA_W + SLOT_W;

  localparam int CLK_HALF      = 5;
  localparam int RESET_CYCLES  = 8;
  localparam int RANDOM_ITEMS  = 1700;
  localparam int LIMIT_CYCLES  = 1000000;
  localparam int SETTLE_CYCLES = 2 * DEPTH + 16;
  localparam int NO_CFG        = -1;

  // Opcodes the block ignores
  localparam logic [OP_W-1:0] OP_RSVD_LO = 3'd5;
  localparam logic [OP_W-1:0] OP_RSVD_HI = 3'd7;

  // Receiver stall modes
  localparam int RX_OPEN      = 0;
  localparam int RX_RANDOM    = 1;
  localparam int RX_ALTERNATE = 2;
  localparam int RX_BURSTY    = 3;

  typedef struct packed {
    logic [ST_W-1:0]   status;
    logic [DATA_W-1:0] data_out;
    logic [SLOT_W-1:0] slot;
    logic [CNT_W-1:0]  count;
  } fifo_result_t;

  typedef struct packed {
    int                cfg;
    logic [OP_W-1:0]   op;
    logic [DATA_W-1:0] data;
    logic              typed;
    fifo_result_t      want;
  } directed_row_t;

  // Directed stimulus; rows with typed = 0 are checked against the predictor
  localparam directed_row_t DIRECTED [26] = '{
    '{NO_CFG, cfws_pkg::OP_POP, 32'h0, 1'b1, '{cfws_pkg::STAT_EMPTY, 32'h0, 6'd0, 7'd0}},
    '{NO_CFG, cfws_pkg::OP_PEEK, 32'h0, 1'b1, '{cfws_pkg::STAT_EMPTY, 32'h0, 6'd0, 7'd0}},
    '{NO_CFG, cfws_pkg::OP_SEARCH, 32'h0, 1'b1,
      '{cfws_pkg::STAT_NOTFOUND, 32'h0, 6'd0, 7'd0}},
    '{NO_CFG, cfws_pkg::OP_PUSH, 32'h7fffffff, 1'b1, '{cfws_pkg::STAT_OK, 32'h0, 6'd0, 7'd1}},
    '{NO_CFG, cfws_pkg::OP_PUSH, 32'h80000000, 1'b1, '{cfws_pkg::STAT_OK, 32'h0, 6'd0, 7'd2}},
    '{NO_CFG, cfws_pkg::OP_PUSH, 32'h0, 1'b1, '{cfws_pkg::STAT_OK, 32'h0, 6'd0, 7'd3}},
    '{NO_CFG, cfws_pkg::OP_PUSH, 32'hffffffff, 1'b1, '{cfws_pkg::STAT_OK, 32'h0, 6'd0, 7'd4}},
    '{NO_CFG, cfws_pkg::OP_PUSH, 32'hffffffff, 1'b0, '0},
    '{NO_CFG, cfws_pkg::OP_PEEK, 32'h0, 1'b1,
      '{cfws_pkg::STAT_OK, 32'h7fffffff, 6'd0, 7'd5}},
    '{NO_CFG, cfws_pkg::OP_SEARCH, 32'hffffffff, 1'b0, '0},
    '{NO_CFG, cfws_pkg::OP_SEARCH, 32'h80000000, 1'b0, '0},
    '{NO_CFG, cfws_pkg::OP_SEARCH, 32'h12345678, 1'b1,
      '{cfws_pkg::STAT_NOTFOUND, 32'h0, 6'd0, 7'd5}},
    '{NO_CFG, OP_RSVD_LO, 32'h0, 1'b1, '{cfws_pkg::STAT_OK, 32'h0, 6'd0, 7'd5}},
    '{NO_CFG, OP_RSVD_HI, 32'hffffffff, 1'b1, '{cfws_pkg::STAT_OK, 32'h0, 6'd0, 7'd5}},
    '{NO_CFG, cfws_pkg::OP_POP, 32'h0, 1'b1, '{cfws_pkg::STAT_OK, 32'h7fffffff, 6'd0, 7'd4}},
    '{NO_CFG, cfws_pkg::OP_CLEAR, 32'h0, 1'b1, '{cfws_pkg::STAT_OK, 32'h0, 6'd0, 7'd0}},
    '{NO_CFG, cfws_pkg::OP_PEEK, 32'h0, 1'b1, '{cfws_pkg::STAT_EMPTY, 32'h0, 6'd0, 7'd0}},
    '{1, cfws_pkg::OP_PUSH, 32'h55, 1'b1, '{cfws_pkg::STAT_OK, 32'h0, 6'd0, 7'd1}},
    '{NO_CFG, cfws_pkg::OP_PUSH, 32'h66, 1'b1, '{cfws_pkg::STAT_FULL, 32'h0, 6'd0, 7'd1}},
    '{NO_CFG, cfws_pkg::OP_SEARCH, 32'h55, 1'b0, '0},
    '{NO_CFG, cfws_pkg::OP_POP, 32'h0, 1'b0, '0},
    '{0, cfws_pkg::OP_PUSH, 32'haaaa, 1'b0, '0},
    '{NO_CFG, cfws_pkg::OP_PUSH, 32'hbbbb, 1'b1, '{cfws_pkg::STAT_FULL, 32'h0, 6'd0, 7'd1}},
    '{NO_CFG, cfws_pkg::OP_SEARCH, 32'haaaa, 1'b0, '0},
    '{127, cfws_pkg::OP_CLEAR, 32'h0, 1'b1, '{cfws_pkg::STAT_OK, 32'h0, 6'd0, 7'd0}},
    '{NO_CFG, cfws_pkg::OP_PUSH, 32'h6, 1'b0, '0}
  };

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CNT_W-1:0]    cfg_wdata_i;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [IN_TW-1:0]    s_axis_tdata;   // data_in
  logic [OP_W-1:0]     s_axis_tuser;   // opcode
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OUT_TW-1:0]   m_axis_tdata;   // data_out, slot_index, fill_count
  logic [ST_W-1:0]     m_axis_tuser;   // status

  circular_fifo_with_search i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #(CLK_HALF) clk_i = ~clk_i;

  // Predictor state: storage, pointers, count and capacity register
  logic [DATA_W-1:0] fifo_mem [DEPTH];
  bit                slot_written [DEPTH];
  logic [SLOT_W-1:0] wr_ptr;
  logic [SLOT_W-1:0] rd_ptr;
  logic [CNT_W-1:0]  held;
  logic [CNT_W-1:0]  cap_reg;

  fifo_result_t expected_results [$];
  int           err_count;
  int           cycle_count;
  int           burst_left;
  bit           steady;

  // Capacity as the block uses it: 0 acts as 1, above DEPTH acts as DEPTH
  function automatic int eff_cap();
    if (cap_reg == '0) return 1;
    if (cap_reg > CNT_W'(DEPTH)) return DEPTH;
    return int'(cap_reg);
  endfunction

  // Pointers move downward and wrap from slot 0 to capacity-1
  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
    return (s == '0) ? SLOT_W'(eff_cap() - 1) : s - SLOT_W'(1);
  endfunction

  // Result of one item; state moves only when commit is set.
  // blank flags a read of a slot never written.
  function automatic void predict(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] din,
                                  input bit commit, output fifo_result_t res,
                                  output bit blank);
    logic [SLOT_W-1:0] s;
    int n;
    res   = '0;
    blank = 1'b0;
    case (op) inside
      cfws_pkg::OP_PUSH: begin
        if (int'(held) >= eff_cap()) begin
          res.status = cfws_pkg::STAT_FULL;
        end else if (commit) begin
          fifo_mem[wr_ptr]     = din;
          slot_written[wr_ptr] = 1'b1;
          held                 = held + CNT_W'(1);
          wr_ptr               = next_slot(wr_ptr);
        end
      end
      cfws_pkg::OP_POP, cfws_pkg::OP_PEEK: begin
        if (held == '0) begin
          res.status = cfws_pkg::STAT_EMPTY;
        end else begin
          blank        = !slot_written[rd_ptr];
          res.data_out = fifo_mem[rd_ptr];
          if (commit && op == cfws_pkg::OP_POP) begin
            held   = held - CNT_W'(1);
            rd_ptr = next_slot(rd_ptr);
          end
        end
      end
      cfws_pkg::OP_SEARCH: begin
        // oldest to newest, first hit wins
        res.status = cfws_pkg::STAT_NOTFOUND;
        s = rd_ptr;
        for (n = 0; n < int'(held) && n < DEPTH; n++) begin
          blank |= !slot_written[s];
          if (fifo_mem[s] == din) begin
            res.status = cfws_pkg::STAT_OK;
            res.slot   = s;
            break;
          end
          s = next_slot(s);
        end
      end
      cfws_pkg::OP_CLEAR: begin
        if (commit) begin
          wr_ptr = '0;
          rd_ptr = '0;
          held   = '0;
        end
      end
      default: ;
    endcase
    res.count = held;
  endfunction

  // Mix of wide random words, small values (for duplicates) and extremes
  function automatic logic [DATA_W-1:0] random_word();
    case ($urandom_range(0, 7))
      0: return DATA_W'($urandom_range(0, 7));
      1: begin
        case ($urandom_range(0, 3))
          0: return 32'h80000000;
          1: return 32'h7fffffff;
          2: return 32'h0;
          default: return 32'hffffffff;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    err_count++;
    $display("%0t %s: got %0h, want %0h", $time, what, got, want);
  endtask

  // Hold off the sender until every pending result has come back
  task automatic drain_wait();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_capacity(input logic [CNT_W-1:0] value);
    drain_wait();
    repeat (4) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    cap_reg      = value;
  endtask

  // Send one item in bursts with random gaps, then log its expected result
  task automatic issue_item(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] data,
                            input logic typed, input fifo_result_t typed_res);
    fifo_result_t res;
    bit blank;
    int gap;
    if ($urandom_range(0, 149) == 0) drain_wait();
    if (burst_left == 0) begin
      gap = steady ? 0 : $urandom_range(0, 12);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_TW'(data);
    s_axis_tuser  <= op;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict(op, data, 1'b1, res, blank);
    expected_results.push_back(typed ? typed_res : res);
  endtask

  // Result checker: each result against the oldest pending expectation
  always @(posedge clk_i) begin : result_check
    fifo_result_t got;
    fifo_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.status   = m_axis_tuser;
      got.data_out = m_axis_tdata[DATA_W-1:0];
      got.slot     = m_axis_tdata[SLOT_LSB +: SLOT_W];
      got.count    = m_axis_tdata[CNT_LSB +: CNT_W];
      if (expected_results.size() == 0) begin
        report_mismatch("result with nothing pending", longint'(got), 0);
      end else begin
        want = expected_results.pop_front();
        if (got.status !== want.status)
          report_mismatch("status", longint'(got.status), longint'(want.status));
        if (got.data_out !== want.data_out)
          report_mismatch("data_out", longint'(got.data_out), longint'(want.data_out));
        if (got.slot !== want.slot)
          report_mismatch("slot_index", longint'(got.slot), longint'(want.slot));
        if (got.count !== want.count)
          report_mismatch("fill_count", longint'(got.count), longint'(want.count));
      end
    end
  end

  // Receiver backpressure; the stall mode is redrawn at random
  int rx_mode    = RX_OPEN;
  int mode_age   = 0;
  int stall_left = 0;
  always @(posedge clk_i) begin
    if (mode_age == 0) begin
      rx_mode  = $urandom_range(RX_OPEN, RX_BURSTY);
      mode_age = $urandom_range(50, 400);
    end
    mode_age--;
    case (rx_mode)
      RX_OPEN:      m_axis_tready <= 1'b1;
      RX_RANDOM:    m_axis_tready <= ($urandom_range(0, 3) != 0);
      RX_ALTERNATE: m_axis_tready <= ~m_axis_tready;
      default: begin
        if (stall_left != 0) begin
          stall_left--;
          m_axis_tready <= 1'b0;
        end else if ($urandom_range(0, 19) == 0) begin
          stall_left = $urandom_range(1, 24);
          m_axis_tready <= 1'b0;
        end else begin
          m_axis_tready <= 1'b1;
        end
      end
    endcase
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("circular_fifo_with_search_tb: done, errors");
      $finish;
    end
  end

  // Main stimulus
  initial begin
    fifo_result_t res;
    bit blank;
    bit filling;
    logic [OP_W-1:0] op;
    logic [DATA_W-1:0] data;
    logic [SLOT_W-1:0] s;
    int random_sent;
    int phase;
    int len;
    int r;
    int cap;

    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    err_count     = 0;
    cycle_count   = 0;
    burst_left    = 0;
    steady        = 1'b0;
    for (int i = 0; i < DEPTH; i++) begin
      fifo_mem[i]     = '0;
      slot_written[i] = 1'b0;
    end
    wr_ptr  = '0;
    rd_ptr  = '0;
    held    = '0;
    cap_reg = CNT_W'(DEPTH);

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part
    foreach (DIRECTED[i]) begin
      if (DIRECTED[i].cfg != NO_CFG) set_capacity(CNT_W'(DIRECTED[i].cfg));
      issue_item(DIRECTED[i].op, DIRECTED[i].data, DIRECTED[i].typed, DIRECTED[i].want);
    end

    // Random phases: new capacity, usually a clear, then fill/drain runs
    random_sent = 0;
    phase       = 0;
    filling     = 1'b1;
    while (random_sent < RANDOM_ITEMS) begin
      if (phase == 0) begin
        cap = DEPTH;
      end else begin
        case ($urandom_range(0, 9)) inside
          0, 1, 2: cap = $urandom_range(1, 8);
          3, 4:    cap = $urandom_range(9, DEPTH - 1);
          5, 6:    cap = DEPTH;
          7:       cap = 0;
          8:       cap = $urandom_range(DEPTH + 1, 127);
          default: cap = $urandom_range(1, DEPTH);
        endcase
      end
      set_capacity(CNT_W'(cap));
      // sometimes keep the held entries across the capacity change
      if (phase == 0 || $urandom_range(0, 4) != 0) begin
        issue_item(cfws_pkg::OP_CLEAR, $urandom, 1'b0, '0);
        random_sent++;
        filling = 1'b1;
      end
      steady = ($urandom_range(0, 3) == 0);
      len    = $urandom_range(40, 220);
      if (len > RANDOM_ITEMS - random_sent) len = RANDOM_ITEMS - random_sent;
      repeat (len) begin
        if (int'(held) >= eff_cap() && $urandom_range(0, 3) == 0) filling = 1'b0;
        if (held == '0 && $urandom_range(0, 2) == 0) filling = 1'b1;
        r = $urandom_range(0, 99);
        if (filling)
          op = (r < 60) ? cfws_pkg::OP_PUSH : (r < 70) ? cfws_pkg::OP_POP :
               (r < 78) ? cfws_pkg::OP_PEEK : (r < 93) ? cfws_pkg::OP_SEARCH :
               (r < 95) ? cfws_pkg::OP_CLEAR :
               OP_W'($urandom_range(OP_RSVD_LO, OP_RSVD_HI));
        else
          op = (r < 15) ? cfws_pkg::OP_PUSH : (r < 65) ? cfws_pkg::OP_POP :
               (r < 73) ? cfws_pkg::OP_PEEK : (r < 93) ? cfws_pkg::OP_SEARCH :
               (r < 95) ? cfws_pkg::OP_CLEAR :
               OP_W'($urandom_range(OP_RSVD_LO, OP_RSVD_HI));
        data = random_word();
        // search mostly for a value that is held, at a random depth
        if (op == cfws_pkg::OP_SEARCH && held != '0 && $urandom_range(0, 9) < 6) begin
          s = rd_ptr;
          repeat ($urandom_range(0, int'(held) - 1)) s = next_slot(s);
          data = fifo_mem[s];
        end
        // never read a slot that was never written
        predict(op, data, 1'b0, res, blank);
        if (blank) op = cfws_pkg::OP_CLEAR;
        issue_item(op, data, 1'b0, '0);
        random_sent++;
      end
      phase++;
    end

    // Wind down
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (err_count == 0) begin
      $display("circular_fifo_with_search_tb: done, clean");
    end else begin
      $display("circular_fifo_with_search_tb: done, errors");
    end
    $finish;
  end

endmodule

>>> files.f
hdl/cfws_pkg.sv
hdl/cfws_ram.sv
hdl/circular_fifo_with_search.sv
verif/circular_fifo_with_search_tb.sv
